FILE: sv/fpfa_pkg.sv
package fpfa_pkg;

   localparam int MAX_BLOCKS = 16;
   localparam int SIZE_BITS  = 16;
   localparam int IDX_BITS   = $clog2(MAX_BLOCKS);
   localparam int CNT_BITS   = $clog2(MAX_BLOCKS + 1);
   localparam int COUNT_W    = 5;
   localparam int MODE_W     = 2;
   localparam int GRANT_W    = 4;
   localparam int CSR_DATA_W = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_FIRST = 2'd0,
      MODE_WORST = 2'd1,
      MODE_BEST  = 2'd2
   } fit_mode_type;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_ALLOC = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_LOADED  = 2'd0,
      ST_GRANTED = 2'd1,
      ST_REFUSED = 2'd2
   } status_type;

   typedef enum logic {
      CSR_FIT_MODE    = 1'b0,
      CSR_BLOCK_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SCAN   = 2'd1,
      S_FINISH = 2'd2
   } state_type;

   typedef struct packed {
      logic                 req_type;
      logic [3:0]           block_index;
      logic [SIZE_BITS-1:0] size_value;
   } req_item_type;

   typedef struct packed {
      status_type         status;
      logic [GRANT_W-1:0] granted_block;
   } rsp_item_type;

   // control from the sequencer to the fit unit
   typedef struct packed {
      logic                clear;
      logic                valid;
      logic                free;
      logic [IDX_BITS-1:0] idx;
   } fit_ctrl_type;

   typedef struct packed {
      logic                found;
      logic [IDX_BITS-1:0] idx;
   } fit_result_type;

endpackage

FILE: sv/fpfa_ram.sv
module fpfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/fpfa_fit_unit.sv
module fpfa_fit_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  fpfa_pkg::fit_ctrl_type         ctrl,
   input  logic [fpfa_pkg::MODE_W-1:0]    fit_mode,
   input  logic [fpfa_pkg::SIZE_BITS-1:0] want,
   input  logic [fpfa_pkg::SIZE_BITS-1:0] cand_size,
   output fpfa_pkg::fit_result_type       result
);

   logic                           found_ff, found_in;
   logic [fpfa_pkg::IDX_BITS-1:0]  idx_ff, idx_in;
   logic [fpfa_pkg::SIZE_BITS-1:0] size_ff, size_in;
   logic                           fits;
   logic                           take;

   // one compare of the candidate against the request and the best so far
   always_comb begin
      fits = ctrl.valid && ctrl.free && (cand_size >= want);
      case (fit_mode)
         fpfa_pkg::MODE_FIRST: take = fits && !found_ff;
         fpfa_pkg::MODE_WORST: take = fits && (!found_ff || cand_size >= size_ff);
         fpfa_pkg::MODE_BEST:  take = fits && (!found_ff || cand_size < size_ff);
         default:              take = 1'b0;
      endcase

      found_in = found_ff;
      idx_in   = idx_ff;
      size_in  = size_ff;
      if (ctrl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         idx_in   = ctrl.idx;
         size_in  = cand_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      idx_ff  <= idx_in;
      size_ff <= size_in;
   end

   assign result.found = found_ff;
   assign result.idx   = idx_ff;

endmodule

FILE: sv/fixed_partition_fit_allocator.sv
// Channel   | Ports                         | Moves
// ----------+-------------------------------+----------------------------------
// request   | req_valid/req_ready/req_data  | load of a block size, or allocate
// response  | rsp_valid/rsp_ready/rsp_data  | status and granted block index
// csr       | csr_wr_en/csr_index/csr_wdata | fit_mode (0), block_count (1)
//
// A load request goes from acceptance straight to the finish step, which loads the
// response register. An allocate request first runs the scan over block_count entries
// (block_count clamped to MAX_BLOCKS) and then passes through the finish step:
// the scan reads one block size per cycle from the size RAM and runs it through the
// single shared fit compare. An allocate refused by the sticky halt skips the scan.
// Reset (synchronous, active high) clears the free bits, the halt and both CSRs;
// the size RAM is not cleared, since a block is never free before it is loaded.
// A new request is taken only in idle; a stalled response holds the block in its
// finish step, and the response register lets the next request in once taken.
module fixed_partition_fit_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  fpfa_pkg::req_item_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output fpfa_pkg::rsp_item_type          rsp_data,
   input  logic                            csr_wr_en,
   input  logic                            csr_index,
   input  logic [fpfa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   fpfa_pkg::state_type               state_ff, state_in;
   logic [fpfa_pkg::MODE_W-1:0]       fit_mode_ff;
   logic [fpfa_pkg::COUNT_W-1:0]      block_count_ff;
   logic [fpfa_pkg::MAX_BLOCKS-1:0]   free_ff, free_in;
   logic                              halted_ff, halted_in;
   logic                              kind_ff, kind_in;
   logic [fpfa_pkg::SIZE_BITS-1:0]    want_ff, want_in;
   logic [fpfa_pkg::CNT_BITS-1:0]     scan_idx_ff, scan_idx_in;
   logic                              cmp_vld_ff, cmp_vld_in;
   logic [fpfa_pkg::IDX_BITS-1:0]     cmp_idx_ff, cmp_idx_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   fpfa_pkg::rsp_item_type            rsp_data_ff, rsp_data_in;

   logic                              req_fire;
   logic                              issue;
   logic [fpfa_pkg::CNT_BITS-1:0]     scan_limit;
   logic [fpfa_pkg::SIZE_BITS-1:0]    cand_size;
   fpfa_pkg::fit_ctrl_type            fit_ctrl;
   fpfa_pkg::fit_result_type          fit_result;

   // Config: take writes as they come; block_count above the depth is clamped.
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff    <= '0;
         block_count_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            fpfa_pkg::CSR_FIT_MODE:    fit_mode_ff    <= csr_wdata[fpfa_pkg::MODE_W-1:0];
            fpfa_pkg::CSR_BLOCK_COUNT: block_count_ff <= csr_wdata[fpfa_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign scan_limit = (block_count_ff > fpfa_pkg::COUNT_W'(fpfa_pkg::MAX_BLOCKS))
                       ? fpfa_pkg::CNT_BITS'(fpfa_pkg::MAX_BLOCKS)
                       : fpfa_pkg::CNT_BITS'(block_count_ff);

   assign req_ready = (state_ff == fpfa_pkg::S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign issue     = (state_ff == fpfa_pkg::S_SCAN) && (scan_idx_ff < scan_limit);

   // Block size store: loads write on acceptance, the scan reads one entry a cycle.
   fpfa_ram #(
      .WIDTH(fpfa_pkg::SIZE_BITS),
      .DEPTH(fpfa_pkg::MAX_BLOCKS)
   ) u_size_ram (
      .clock  (clock),
      .wr_en  (req_fire && (req_data.req_type == fpfa_pkg::REQ_LOAD)),
      .wr_addr(req_data.block_index[fpfa_pkg::IDX_BITS-1:0]),
      .wr_data(req_data.size_value),
      .rd_en  (issue),
      .rd_addr(scan_idx_ff[fpfa_pkg::IDX_BITS-1:0]),
      .rd_data(cand_size)
   );

   // The compare stage sees the entry read in the previous cycle.
   assign fit_ctrl.clear = req_fire;
   assign fit_ctrl.valid = cmp_vld_ff;
   assign fit_ctrl.free  = free_ff[cmp_idx_ff];
   assign fit_ctrl.idx   = cmp_idx_ff;

   fpfa_fit_unit u_fit (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (fit_ctrl),
      .fit_mode (fit_mode_ff),
      .want     (want_ff),
      .cand_size(cand_size),
      .result   (fit_result)
   );

   always_comb begin
      state_in     = state_ff;
      free_in      = free_ff;
      halted_in    = halted_ff;
      kind_in      = kind_ff;
      want_in      = want_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         fpfa_pkg::S_IDLE: begin
            if (req_fire) begin
               kind_in     = req_data.req_type;
               want_in     = req_data.size_value;
               scan_idx_in = '0;
               if (req_data.req_type == fpfa_pkg::REQ_LOAD) begin
                  // a load, even while halted, frees the block it writes
                  free_in[req_data.block_index[fpfa_pkg::IDX_BITS-1:0]] = 1'b1;
                  state_in = fpfa_pkg::S_FINISH;
               end else if (halted_ff) begin
                  state_in = fpfa_pkg::S_FINISH;
               end else begin
                  state_in = fpfa_pkg::S_SCAN;
               end
            end
         end
         fpfa_pkg::S_SCAN: begin
            // advance the read pointer; leave once the last compare has drained
            if (issue) begin
               scan_idx_in = scan_idx_ff + 1'b1;
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = scan_idx_ff[fpfa_pkg::IDX_BITS-1:0];
            end else if (!cmp_vld_ff) begin
               state_in = fpfa_pkg::S_FINISH;
            end
         end
         fpfa_pkg::S_FINISH: begin
            // hold here until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.granted_block = '0;
               state_in                  = fpfa_pkg::S_IDLE;
               if (kind_ff == fpfa_pkg::REQ_LOAD) begin
                  rsp_data_in.status = fpfa_pkg::ST_LOADED;
               end else if (!halted_ff && fit_result.found) begin
                  rsp_data_in.status        = fpfa_pkg::ST_GRANTED;
                  rsp_data_in.granted_block = fpfa_pkg::GRANT_W'(fit_result.idx);
                  free_in[fit_result.idx]   = 1'b0;
               end else begin
                  // the first refusal sets the sticky halt
                  rsp_data_in.status = fpfa_pkg::ST_REFUSED;
                  halted_in          = 1'b1;
               end
            end
         end
         default: begin
            state_in = fpfa_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpfa_pkg::S_IDLE;
         free_ff      <= '0;
         halted_ff    <= 1'b0;
         scan_idx_ff  <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         halted_ff    <= halted_in;
         scan_idx_ff  <= scan_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      want_ff     <= want_in;
      cmp_idx_ff  <= cmp_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: test/tb_fixed_partition_fit_allocator.sv
module tb_fixed_partition_fit_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   // Mode three is left unused by the block; every allocation under it is refused.
   localparam logic [fpfa_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int SIZE_TOP = (1 << fpfa_pkg::SIZE_BITS) - 1;

   // Shadow of the partition table: sizes, free bits and the sticky halt.
   typedef struct packed {
      logic [fpfa_pkg::MAX_BLOCKS-1:0][fpfa_pkg::SIZE_BITS-1:0] size;
      logic [fpfa_pkg::MAX_BLOCKS-1:0]                          free;
      logic                                                     halted;
   } partition_table_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_ready;
   fpfa_pkg::req_item_type          req_data    = '0;
   logic                            rsp_valid;
   logic                            rsp_ready   = 1'b0;
   fpfa_pkg::rsp_item_type          rsp_data;
   logic                            csr_wr_en   = 1'b0;
   logic                            csr_index   = 1'b0;
   logic [fpfa_pkg::CSR_DATA_W-1:0] csr_wdata   = '0;

   fixed_partition_fit_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Register copies as last written; only touched while the block is idle.
   logic [fpfa_pkg::MODE_W-1:0]  live_mode  = fpfa_pkg::MODE_FIRST;
   logic [fpfa_pkg::COUNT_W-1:0] live_count = '0;

   fpfa_pkg::req_item_type  queued_requests[$];
   fpfa_pkg::rsp_item_type  awaited_answers[$];
   partition_table_type     table_now;
   partition_table_type     table_plan = '0;

   int   pushed_total   = 0;
   int   answered_total = 0;
   int   failures       = 0;
   int   n_loads        = 0;
   int   n_grants       = 0;
   int   n_refusals     = 0;
   bit   calm           = 1'b0;
   bit   req_taken      = 1'b0;
   int   send_gap       = 0;
   int   hold_asked     = 0;
   int   hold_seen      = 0;
   int   hold_left      = 0;
   int   stall_left     = 0;
   bit   halt_by_mode   = 1'b0;
   fpfa_pkg::rsp_item_type due;

   // Pick the partition an allocation of 'want' gets, or -1 when none fits.
   function automatic int choose_partition(partition_table_type t,
                                           logic [fpfa_pkg::MODE_W-1:0] mode,
                                           logic [fpfa_pkg::COUNT_W-1:0] count,
                                           logic [fpfa_pkg::SIZE_BITS-1:0] want);
      int span;
      int chosen;
      logic [fpfa_pkg::SIZE_BITS-1:0] chosen_size;
      span = (count > fpfa_pkg::MAX_BLOCKS) ? fpfa_pkg::MAX_BLOCKS : int'(count);
      chosen = -1;
      chosen_size = '0;
      if (mode == MODE_UNUSED)
         return -1;
      for (int i = 0; i < span; i++) begin
         if (t.free[i] && t.size[i] >= want) begin
            case (mode)
               fpfa_pkg::MODE_FIRST: begin
                  if (chosen < 0)
                     chosen = i;
               end
               fpfa_pkg::MODE_WORST: begin
                  // largest wins; equal sizes move on to the higher index
                  if (chosen < 0 || t.size[i] >= chosen_size) begin
                     chosen = i;
                     chosen_size = t.size[i];
                  end
               end
               default: begin
                  // smallest wins; equal sizes keep the lower index
                  if (chosen < 0 || t.size[i] < chosen_size) begin
                     chosen = i;
                     chosen_size = t.size[i];
                  end
               end
            endcase
         end
      end
      return chosen;
   endfunction

   function automatic fpfa_pkg::rsp_item_type allocator_answer(
         partition_table_type t,
         logic [fpfa_pkg::MODE_W-1:0] mode,
         logic [fpfa_pkg::COUNT_W-1:0] count,
         fpfa_pkg::req_item_type r);
      fpfa_pkg::rsp_item_type o;
      int pick;
      o.status = fpfa_pkg::ST_LOADED;
      o.granted_block = '0;
      if (r.req_type == fpfa_pkg::REQ_ALLOC) begin
         pick = t.halted ? -1 : choose_partition(t, mode, count, r.size_value);
         if (pick < 0) begin
            o.status = fpfa_pkg::ST_REFUSED;
         end else begin
            o.status = fpfa_pkg::ST_GRANTED;
            o.granted_block = fpfa_pkg::GRANT_W'(pick);
         end
      end
      return o;
   endfunction

   function automatic partition_table_type allocator_after(
         partition_table_type t,
         logic [fpfa_pkg::MODE_W-1:0] mode,
         logic [fpfa_pkg::COUNT_W-1:0] count,
         fpfa_pkg::req_item_type r);
      int pick;
      if (r.req_type == fpfa_pkg::REQ_LOAD) begin
         t.size[r.block_index] = r.size_value;
         t.free[r.block_index] = 1'b1;
      end else if (!t.halted) begin
         pick = choose_partition(t, mode, count, r.size_value);
         if (pick < 0)
            t.halted = 1'b1;
         else
            t.free[pick] = 1'b0;
      end
      return t;
   endfunction

   // Largest free size among the partitions in play, or -1 when none is free.
   function automatic int largest_free(partition_table_type t,
                                       logic [fpfa_pkg::COUNT_W-1:0] count);
      int span;
      int big;
      span = (count > fpfa_pkg::MAX_BLOCKS) ? fpfa_pkg::MAX_BLOCKS : int'(count);
      big = -1;
      for (int i = 0; i < span; i++)
         if (t.free[i] && int'(t.size[i]) > big)
            big = int'(t.size[i]);
      return big;
   endfunction

   function automatic int random_size();
      case ($urandom_range(0, 19))
         0:       return 0;
         1, 2:    return SIZE_TOP;
         3:       return 1;
         4, 5, 6, 7, 8: return $urandom_range(1, 64);
         default: return $urandom_range(0, SIZE_TOP);
      endcase
   endfunction

   function automatic logic [fpfa_pkg::MODE_W-1:0] any_fit_mode();
      case ($urandom_range(0, 2))
         0:       return fpfa_pkg::MODE_FIRST;
         1:       return fpfa_pkg::MODE_WORST;
         default: return fpfa_pkg::MODE_BEST;
      endcase
   endfunction

   // Driver: present the next queued request at the falling edge and hold it,
   // unchanged, until the rising edge that takes it.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0 && !calm) begin
            send_gap = send_gap - 1;
            req_valid <= 1'b0;
         end else if (queued_requests.size() != 0) begin
            req_data  <= queued_requests.pop_front();
            req_valid <= 1'b1;
            // leave a burst of idle cycles behind this request now and then
            if (!calm && $urandom_range(0, 6) == 0)
               send_gap = $urandom_range(1, 18);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure: random stall bursts, plus one long hold-off when
   // asked, so that the block backs up and drops req_ready.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = 300;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 18);
      end
   end

   // Monitor: predict each taken request at the edge that takes it, then check
   // any response handed over at the same edge against the oldest prediction.
   always @(posedge clock) begin
      req_taken = !reset && req_valid && req_ready;
      if (reset) begin
         table_now = '0;
         awaited_answers.delete();
      end else begin
         if (req_taken) begin
            awaited_answers.push_back(allocator_answer(table_now, live_mode, live_count,
                                                       req_data));
            table_now = allocator_after(table_now, live_mode, live_count, req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_answers.size() == 0) begin
               $display("%0t: response with none expected: status %0d block %0d",
                        $realtime, rsp_data.status, rsp_data.granted_block);
               failures++;
            end else begin
               due = awaited_answers.pop_front();
               answered_total++;
               case (due.status)
                  fpfa_pkg::ST_LOADED:  n_loads++;
                  fpfa_pkg::ST_GRANTED: n_grants++;
                  default:              n_refusals++;
               endcase
               if (rsp_data.status !== due.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $realtime, due.status, rsp_data.status);
                  failures++;
               end
               if (rsp_data.granted_block !== due.granted_block) begin
                  $display("%0t: granted_block mismatch, expected %0d, got %0d",
                           $realtime, due.granted_block, rsp_data.granted_block);
                  failures++;
               end
            end
         end
      end
   end

   // Queue a request and advance the planning copy of the table with it, so
   // that later stimulus can be shaped to what the pool will hold.
   task automatic push_request(input fpfa_pkg::req_kind_type kind, input int idx,
                               input int sz);
      fpfa_pkg::req_item_type r;
      r.req_type    = kind;
      r.block_index = idx[3:0];
      r.size_value  = sz[fpfa_pkg::SIZE_BITS-1:0];
      table_plan = allocator_after(table_plan, live_mode, live_count, r);
      queued_requests.push_back(r);
      pushed_total++;
   endtask

   task automatic wait_drained();
      while (answered_total != pushed_total)
         @(negedge clock);
   endtask

   task automatic write_csr(input fpfa_pkg::csr_index_type idx,
                            input logic [fpfa_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == fpfa_pkg::CSR_FIT_MODE)
         live_mode = value[fpfa_pkg::MODE_W-1:0];
      else
         live_count = value[fpfa_pkg::COUNT_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Change settings only once the block has answered everything.
   task automatic set_config(input logic [fpfa_pkg::MODE_W-1:0] mode, input int count);
      wait_drained();
      write_csr(fpfa_pkg::CSR_FIT_MODE, fpfa_pkg::CSR_DATA_W'(mode));
      write_csr(fpfa_pkg::CSR_BLOCK_COUNT, fpfa_pkg::CSR_DATA_W'(count));
   endtask

   // Mostly well-formed traffic: allocations only where the plan says one fits,
   // otherwise loads that refill the pool, now and then beyond the count.
   task automatic random_requests(input int n);
      int big;
      int want;
      int span;
      repeat (n) begin
         big = largest_free(table_plan, live_count);
         span = (live_count > fpfa_pkg::MAX_BLOCKS) ? fpfa_pkg::MAX_BLOCKS
                                                    : int'(live_count);
         if (big >= 0 && $urandom_range(0, 99) < 55) begin
            case ($urandom_range(0, 9))
               0:       want = 0;
               1:       want = big;
               default: want = $urandom_range(0, big);
            endcase
            push_request(fpfa_pkg::REQ_ALLOC, $urandom_range(0, 15), want);
         end else if (span > 0 && $urandom_range(0, 99) < 80) begin
            push_request(fpfa_pkg::REQ_LOAD, $urandom_range(0, span - 1), random_size());
         end else begin
            push_request(fpfa_pkg::REQ_LOAD, $urandom_range(0, 15), random_size());
         end
      end
   endtask

   initial begin
      int big;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed: first fit over four blocks, a zero-size request, a block
      // loaded beyond the count, extreme sizes and reloading a used block.
      set_config(fpfa_pkg::MODE_FIRST, 4);
      push_request(fpfa_pkg::REQ_LOAD, 0, SIZE_TOP);
      push_request(fpfa_pkg::REQ_LOAD, 1, 1);
      push_request(fpfa_pkg::REQ_LOAD, 2, 300);
      push_request(fpfa_pkg::REQ_LOAD, 3, 300);
      push_request(fpfa_pkg::REQ_LOAD, 15, 7);
      push_request(fpfa_pkg::REQ_ALLOC, 0, 0);
      push_request(fpfa_pkg::REQ_ALLOC, 9, 2);
      push_request(fpfa_pkg::REQ_LOAD, 0, 100);
      push_request(fpfa_pkg::REQ_ALLOC, 15, 100);

      // Worst fit with an oversized count: equal sizes go to the higher index,
      // a full-range request, and index fifteen now takes part.
      set_config(fpfa_pkg::MODE_WORST, 31);
      push_request(fpfa_pkg::REQ_LOAD, 4, 300);
      push_request(fpfa_pkg::REQ_ALLOC, 0, 1);
      push_request(fpfa_pkg::REQ_LOAD, 14, SIZE_TOP);
      push_request(fpfa_pkg::REQ_ALLOC, 0, SIZE_TOP);
      push_request(fpfa_pkg::REQ_ALLOC, 0, 7);
      push_request(fpfa_pkg::REQ_ALLOC, 0, 5);

      // Best fit: equal sizes keep the lower index; a zero-sized block.
      set_config(fpfa_pkg::MODE_BEST, 16);
      push_request(fpfa_pkg::REQ_LOAD, 5, 50);
      push_request(fpfa_pkg::REQ_LOAD, 6, 50);
      push_request(fpfa_pkg::REQ_LOAD, 7, 49);
      push_request(fpfa_pkg::REQ_LOAD, 8, 0);
      push_request(fpfa_pkg::REQ_ALLOC, 0, 50);
      push_request(fpfa_pkg::REQ_ALLOC, 0, 1);
      push_request(fpfa_pkg::REQ_ALLOC, 0, 0);

      // Random phases over several settings, extremes of the count among them.
      set_config(fpfa_pkg::MODE_FIRST, 1);
      random_requests(50);

      set_config(fpfa_pkg::MODE_WORST, 16);
      hold_asked++;                    // long receiver hold-off while requests queue up
      random_requests(50);

      set_config(fpfa_pkg::MODE_BEST, 0);
      random_requests(40);

      set_config(fpfa_pkg::MODE_FIRST, 31);
      random_requests(25);
      wait_drained();                  // sender pauses until all answers are in
      random_requests(25);

      set_config(fpfa_pkg::MODE_BEST, $urandom_range(2, 15));
      random_requests(50);

      set_config(fpfa_pkg::MODE_WORST, $urandom_range(17, 30));
      random_requests(50);

      set_config(any_fit_mode(), 16);
      random_requests(50);

      // Final part, with no idling: fill the table, then trip the sticky halt,
      // either through mode three or through a request that nothing fits.
      wait_drained();
      calm = 1'b1;
      set_config(any_fit_mode(), 16);
      for (int i = 0; i < fpfa_pkg::MAX_BLOCKS; i++)
         push_request(fpfa_pkg::REQ_LOAD, i, $urandom_range(1, 60000));
      repeat (4) begin
         big = largest_free(table_plan, live_count);
         push_request(fpfa_pkg::REQ_ALLOC, $urandom_range(0, 15), $urandom_range(0, big));
      end
      halt_by_mode = $urandom_range(0, 1);
      if (halt_by_mode) begin
         set_config(MODE_UNUSED, 16);
         push_request(fpfa_pkg::REQ_ALLOC, 0, 0);
      end else begin
         big = largest_free(table_plan, live_count);
         push_request(fpfa_pkg::REQ_ALLOC, 0, $urandom_range(big + 1, SIZE_TOP));
      end

      // Loads still land while halted; every allocation is refused from here.
      repeat (4)
         push_request(fpfa_pkg::REQ_LOAD, $urandom_range(0, 15), random_size());
      set_config(fpfa_pkg::MODE_FIRST, 16);
      random_requests(15);
      set_config(fpfa_pkg::MODE_WORST, 31);
      random_requests(15);

      wait_drained();
      repeat (30) @(negedge clock);

      $display("Ran %0d requests: %0d loads, %0d grants, %0d refusals.",
               pushed_total, n_loads, n_grants, n_refusals);
      $display("Covered first, worst and best fit, counts 0 to 31; halt tripped by %s.",
               halt_by_mode ? "the unused mode" : "a request no block could fit");
      if (awaited_answers.size() != 0)
         $display("%0t: %0d expected responses never arrived",
                  $realtime, awaited_answers.size());
      if (failures == 0 && awaited_answers.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog: several times what a correct run needs, even under the longest stalls.
   initial begin
      #2_000_000;
      $display("%0t: run timed out with %0d of %0d answers in",
               $realtime, answered_total, pushed_total);
      $display("Test completed with failures");
      $finish;
   end

endmodule
